/* rtl/core/cursor_table_interpolator_top_macros.svh */
// Assertion macros shared by the core.
`ifndef CURSOR_TABLE_INTERPOLATOR_TOP_MACROS_SVH
`define CURSOR_TABLE_INTERPOLATOR_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CTI_ASSERT_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("cti assertion failed");
`define CTI_ASSERT_NXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("cti assertion failed");
`else
`define CTI_ASSERT_IMP(lbl, clk, rst, a, b)
`define CTI_ASSERT_NXT(lbl, clk, rst, a, b)
`endif
`endif

/* rtl/core/cti_pkg.sv */
package cti_pkg;
  localparam int TABLE_ROWS = 256;
  localparam int MAX_COLS  = 4;
  localparam int ROW_W     = 8;
  localparam int COL_W     = 2;
  localparam int X_W       = 48;
  localparam int Y_W       = 32;
  localparam int CNT_W     = 7;
  localparam int MUL_STEPS = 32;
  localparam int DIV_STEPS = 81;
  localparam int PROD_W    = 81;
  localparam int QUO_W     = 41;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_LINEAR = 2'd1;
  localparam logic [1:0] OP_STEP   = 2'd2;

  localparam logic [2:0] ST_INSIDE = 3'd0;
  localparam logic [2:0] ST_BELOW  = 3'd1;
  localparam logic [2:0] ST_ABOVE  = 3'd2;
  localparam logic [2:0] ST_EMPTY  = 3'd3;
  localparam logic [2:0] ST_SINGLE = 3'd4;
  localparam logic [2:0] ST_LOAD   = 3'd5;

  localparam logic [1:0] AS_ZERO = 2'd0;
  localparam logic [1:0] AS_LAST = 2'd1;
  localparam logic [1:0] AS_I    = 2'd2;
  localparam logic [1:0] AS_I1   = 2'd3;

  localparam logic [1:0] CUR_KEEP = 2'd0;
  localparam logic [1:0] CUR_ZERO = 2'd1;
  localparam logic [1:0] CUR_LAST = 2'd2;
  localparam logic [1:0] CUR_I    = 2'd3;

  localparam logic [1:0] VS_ZERO = 2'd0;
  localparam logic [1:0] VS_YR   = 2'd1;
  localparam logic [1:0] VS_Y0   = 2'd2;
  localparam logic [1:0] VS_SUM  = 2'd3;

  localparam logic SS_ZERO = 1'b0;
  localparam logic SS_CUR  = 1'b1;

  typedef struct packed {
    logic       capture;
    logic       load_wr;
    logic [1:0] xsel;
    logic [1:0] ysel;
    logic       save_xi;
    logic       save_pair;
    logic       i_init;
    logic       i_inc;
    logic       i_dec;
    logic [1:0] cur_sel;
    logic       mul_init;
    logic       mul_step;
    logic       div_init;
    logic       div_step;
    logic       emit;
    logic [1:0] vsel;
    logic       ssel;
    logic [2:0] st;
  } cti_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic n_one;
    logic x_lt_q;
    logic x_eq_q;
    logic dx_pos;
    logic i_zero;
    logic is_step;
  } cti_sts_t;
endpackage

/* rtl/core/cti_datapath.sv */
module cti_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [8:0]                   cfg_data,
  input  logic [1:0]                   operation,
  input  logic [cti_pkg::ROW_W-1:0]    row,
  input  logic [cti_pkg::COL_W-1:0]    column,
  input  logic signed [cti_pkg::X_W-1:0] x_value,
  input  logic signed [cti_pkg::Y_W-1:0] y_value,
  input  logic signed [cti_pkg::X_W-1:0] query,
  input  cti_pkg::cti_cmd_t            cmd,
  output cti_pkg::cti_sts_t            sts,
  output logic signed [cti_pkg::Y_W-1:0] value,
  output logic [cti_pkg::ROW_W-1:0]    segment,
  output logic [2:0]                   status
);
  import cti_pkg::*;

  logic [8:0] rows;
  logic [2:0] cols;
  logic [ROW_W-1:0] cursor;
  logic [ROW_W-1:0] i;
  logic [1:0] op_r;
  logic [COL_W-1:0] col_r;
  logic signed [X_W-1:0] q_r;
  logic signed [X_W-1:0] x_mem [TABLE_ROWS];
  logic signed [Y_W-1:0] y_mem [TABLE_ROWS*MAX_COLS];
  logic signed [X_W-1:0] xr, xi, x1;
  logic signed [Y_W-1:0] yr, y0;
  logic [ROW_W-1:0] xaddr, yrow;
  logic [8:0] n, n2;
  logic [2:0] nc;
  logic [ROW_W-1:0] last, i_start;
  logic signed [X_W:0] dx, num;
  logic signed [Y_W:0] dy;
  logic [X_W:0] mc;
  logic [X_W:0] mcr;
  logic [X_W-1:0] d_r;
  logic neg;
  logic [PROD_W-1:0] prod;
  logic [X_W+1:0] psum;
  logic [X_W-1:0] rem;
  logic [X_W:0] t;
  logic ge;
  logic [QUO_W-1:0] quo, mag;
  logic ovf;
  logic signed [42:0] fsum;
  logic signed [Y_W-1:0] sat;

  assign n  = (rows > 9'(TABLE_ROWS)) ? 9'(TABLE_ROWS) : rows;
  assign nc = (cols > 3'(MAX_COLS)) ? 3'(MAX_COLS) : cols;
  assign last = 8'(n - 9'd1);
  assign n2 = n - 9'd2;
  assign i_start = ({1'b0, cursor} < n2) ? cursor : n2[ROW_W-1:0];

  always_comb begin
    unique case (cmd.xsel)
      AS_ZERO: xaddr = '0;
      AS_LAST: xaddr = last;
      AS_I:    xaddr = i;
      default: xaddr = i + 8'd1;
    endcase
    unique case (cmd.ysel)
      AS_ZERO: yrow = '0;
      AS_LAST: yrow = last;
      AS_I:    yrow = i;
      default: yrow = i + 8'd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      x_mem[row] <= x_value;
      y_mem[{row, column}] <= y_value;
    end
    xr <= x_mem[xaddr];
    yr <= y_mem[{yrow, col_r}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= '0;
      cols <= 3'd1;
    end else if (cfg_we) begin
      if (cfg_index) cols <= cfg_data[2:0];
      else rows <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
    end else begin
      unique case (cmd.cur_sel)
        CUR_KEEP: cursor <= cursor;
        CUR_ZERO: cursor <= '0;
        CUR_LAST: cursor <= last;
        default:  cursor <= i;
      endcase
    end
  end

  assign dx  = 49'(x1) - 49'(xi);
  assign num = 49'(q_r) - 49'(xi);
  assign dy  = 33'(yr) - 33'(y0);
  assign mc  = num[X_W] ? 49'(-num) : 49'(num);
  assign psum = {1'b0, prod[PROD_W-1:Y_W]} + (prod[0] ? {1'b0, mcr} : '0);

  assign t  = {rem, prod[PROD_W-1]};
  assign ge = t >= {1'b0, d_r};
  assign mag = (ovf || quo > (QUO_W'(1) << (QUO_W-1))) ? (QUO_W'(1) << (QUO_W-1)) : quo;
  assign fsum = 43'(y0) + (neg ? -43'(mag) : 43'(mag));
  always_comb begin
    if (fsum > 43'sd2147483647) sat = 32'sh7fffffff;
    else if (fsum < -43'sd2147483648) sat = 32'sh80000000;
    else sat = fsum[Y_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= operation;
      col_r <= ({1'b0, column} < nc) ? column : '0;
      q_r   <= query;
    end
    if (cmd.i_init) i <= i_start;
    else if (cmd.i_inc) i <= i + 8'd1;
    else if (cmd.i_dec) i <= i - 8'd1;
    if (cmd.save_xi) xi <= xr;
    if (cmd.save_pair) begin
      x1 <= xr;
      y0 <= yr;
    end
    if (cmd.mul_init) begin
      mcr  <= mc;
      d_r  <= dx[X_W-1:0];
      neg  <= num[X_W] ^ dy[Y_W];
      prod <= {49'd0, (dy[Y_W] ? 32'(-dy) : dy[Y_W-1:0])};
    end else if (cmd.mul_step) begin
      prod <= {psum, prod[Y_W-1:1]};
    end else if (cmd.div_step) begin
      prod <= {prod[PROD_W-2:0], 1'b0};
    end
    if (cmd.div_init) begin
      rem <= '0;
      quo <= '0;
      ovf <= 1'b0;
    end else if (cmd.div_step) begin
      rem <= ge ? 48'(t - {1'b0, d_r}) : t[X_W-1:0];
      quo <= {quo[QUO_W-2:0], ge};
      ovf <= ovf | quo[QUO_W-1];
    end
    if (cmd.emit) begin
      unique case (cmd.vsel)
        VS_ZERO: value <= '0;
        VS_YR:   value <= yr;
        VS_Y0:   value <= y0;
        default: value <= sat;
      endcase
      segment <= (cmd.ssel == SS_CUR) ? cursor : '0;
      status  <= cmd.st;
    end
  end

  assign sts.n_zero  = (n == 9'd0);
  assign sts.n_one   = (n == 9'd1);
  assign sts.x_lt_q  = xr < q_r;
  assign sts.x_eq_q  = xr == q_r;
  assign sts.dx_pos  = !dx[X_W] && (dx != '0);
  assign sts.i_zero  = (i == '0);
  assign sts.is_step = (op_r == OP_STEP);
endmodule

/* rtl/core/cti_controller.sv */
`include "cursor_table_interpolator_top_macros.svh"
module cti_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        operation,
  input  cti_pkg::cti_sts_t sts,
  output cti_pkg::cti_cmd_t cmd,
  output logic              busy,
  output logic              done
);
  import cti_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHK    = 4'd1;
  localparam logic [3:0] S_X0     = 4'd2;
  localparam logic [3:0] S_XL     = 4'd3;
  localparam logic [3:0] S_FWD_RD = 4'd4;
  localparam logic [3:0] S_FWD    = 4'd5;
  localparam logic [3:0] S_BK_RD  = 4'd6;
  localparam logic [3:0] S_BK     = 4'd7;
  localparam logic [3:0] S_WY     = 4'd8;
  localparam logic [3:0] S_RD1    = 4'd9;
  localparam logic [3:0] S_RD2    = 4'd10;
  localparam logic [3:0] S_MUL    = 4'd11;
  localparam logic [3:0] S_DIV    = 4'd12;
  localparam logic [3:0] S_FIN    = 4'd13;

  logic [3:0] state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [2:0] pend, pend_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    cnt_next = cnt;
    pend_next = pend;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          if (operation == OP_LOAD) begin
            cmd.load_wr = 1'b1;
            cmd.emit = 1'b1;
            cmd.vsel = VS_ZERO;
            cmd.ssel = SS_ZERO;
            cmd.st = ST_LOAD;
          end else if (operation == OP_LINEAR || operation == OP_STEP) begin
            state_next = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (sts.n_zero) begin
          cmd.emit = 1'b1;
          cmd.vsel = VS_ZERO;
          cmd.ssel = SS_CUR;
          cmd.st = ST_EMPTY;
          state_next = S_IDLE;
        end else if (sts.n_one) begin
          cmd.ysel = AS_ZERO;
          pend_next = ST_SINGLE;
          state_next = S_WY;
        end else begin
          cmd.xsel = AS_ZERO;
          state_next = S_X0;
        end
      end
      S_WY: begin
        cmd.emit = 1'b1;
        cmd.vsel = VS_YR;
        cmd.ssel = SS_CUR;
        cmd.st = pend;
        state_next = S_IDLE;
      end
      S_X0: begin
        if (sts.is_step ? (!sts.x_lt_q && !sts.x_eq_q) : !sts.x_lt_q) begin
          cmd.cur_sel = CUR_ZERO;
          if (sts.is_step) begin
            cmd.emit = 1'b1;
            cmd.vsel = VS_ZERO;
            cmd.ssel = SS_ZERO;
            cmd.st = ST_BELOW;
            state_next = S_IDLE;
          end else begin
            cmd.ysel = AS_ZERO;
            pend_next = ST_BELOW;
            state_next = S_WY;
          end
        end else begin
          cmd.xsel = AS_LAST;
          state_next = S_XL;
        end
      end
      S_XL: begin
        if (sts.x_lt_q || sts.x_eq_q) begin
          cmd.cur_sel = CUR_LAST;
          cmd.ysel = AS_LAST;
          pend_next = ST_ABOVE;
          state_next = S_WY;
        end else begin
          cmd.i_init = 1'b1;
          state_next = S_FWD_RD;
        end
      end
      S_FWD_RD: begin
        cmd.xsel = AS_I1;
        state_next = S_FWD;
      end
      S_FWD: begin
        if (sts.is_step ? (sts.x_lt_q || sts.x_eq_q) : sts.x_lt_q) begin
          cmd.i_inc = 1'b1;
          state_next = S_FWD_RD;
        end else begin
          state_next = S_BK_RD;
        end
      end
      S_BK_RD: begin
        cmd.xsel = AS_I;
        state_next = S_BK;
      end
      S_BK: begin
        if (!sts.i_zero && !sts.x_lt_q && !sts.x_eq_q) begin
          cmd.i_dec = 1'b1;
          state_next = S_BK_RD;
        end else begin
          cmd.cur_sel = CUR_I;
          cmd.save_xi = 1'b1;
          cmd.ysel = AS_I;
          if (sts.is_step) begin
            pend_next = ST_INSIDE;
            state_next = S_WY;
          end else begin
            cmd.xsel = AS_I1;
            state_next = S_RD1;
          end
        end
      end
      S_RD1: begin
        cmd.save_pair = 1'b1;
        cmd.ysel = AS_I1;
        state_next = S_RD2;
      end
      S_RD2: begin
        if (!sts.dx_pos) begin
          cmd.emit = 1'b1;
          cmd.vsel = VS_Y0;
          cmd.ssel = SS_CUR;
          cmd.st = ST_INSIDE;
          state_next = S_IDLE;
        end else begin
          cmd.mul_init = 1'b1;
          cnt_next = '0;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (cnt == CNT_W'(MUL_STEPS - 1)) begin
          cmd.div_init = 1'b1;
          cnt_next = '0;
          state_next = S_DIV;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_FIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_FIN: begin
        cmd.emit = 1'b1;
        cmd.vsel = VS_SUM;
        cmd.ssel = SS_CUR;
        cmd.st = ST_INSIDE;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      pend <= ST_INSIDE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      pend <= pend_next;
      done <= cmd.emit;
    end
  end

  assign busy = (state != S_IDLE);

  `CTI_ASSERT_IMP(a_mul_cnt, clk, rst, state == S_MUL, cnt < CNT_W'(MUL_STEPS))
  `CTI_ASSERT_NXT(a_load_done, clk, rst, start && !busy && operation == OP_LOAD, done)
  `CTI_ASSERT_NXT(a_div_exit, clk, rst, state == S_DIV, state == S_DIV || state == S_FIN)
endmodule

/* rtl/core/cursor_table_interpolator_top.sv */
// Table interpolator: a command is taken when start is high and busy low. Each
// accepted load, linear or step command gives one result on value/segment/status,
// valid for the single cycle that done is high; the receiver cannot stall, so
// sample it then. Operation code 3 is taken and gives no result. A load gives its
// result in the cycle after it is accepted. A lookup reads the x and y table
// memories one row at a time as the cursor walks, and a linear lookup that
// interpolates inside the table then runs 32 steps of the serial multiplier and
// 81 steps of the serial divider. A new command may be taken in the cycle done is
// high. Configuration is always ready and must be written only while the core is
// idle.
module cursor_table_interpolator_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     operation,
  input  logic [cti_pkg::ROW_W-1:0]      row,
  input  logic [cti_pkg::COL_W-1:0]      column,
  input  logic signed [cti_pkg::X_W-1:0] x_value,
  input  logic signed [cti_pkg::Y_W-1:0] y_value,
  input  logic signed [cti_pkg::X_W-1:0] query,
  output logic                           done,
  output logic signed [cti_pkg::Y_W-1:0] value,
  output logic [cti_pkg::ROW_W-1:0]      segment,
  output logic [2:0]                     status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [8:0]                     cfg_data
);
  import cti_pkg::*;

  cti_cmd_t cmd;
  cti_sts_t sts;

  assign cfg_ready = 1'b1;

  cti_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done)
  );

  cti_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .operation (operation),
    .row       (row),
    .column    (column),
    .x_value   (x_value),
    .y_value   (y_value),
    .query     (query),
    .cmd       (cmd),
    .sts       (sts),
    .value     (value),
    .segment   (segment),
    .status    (status)
  );
endmodule

/* test/tb_cursor_table_interpolator_top.sv */
module tb_cursor_table_interpolator_top;
  import cti_pkg::*;

  typedef struct packed {
    logic [1:0]         op;
    logic [7:0]         row;
    logic [1:0]         col;
    logic signed [47:0] x;
    logic signed [31:0] y;
    logic signed [47:0] q;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [7:0]         segment;
    logic [2:0]         status;
  } lookup_t;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic       REG_ROWS = 1'b0;
  localparam logic       REG_COLS = 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] operation = '0;
  logic [7:0] row = '0;
  logic [1:0] column = '0;
  logic signed [47:0] x_value = '0;
  logic signed [31:0] y_value = '0;
  logic signed [47:0] query = '0;
  logic cfg_valid = 1'b0;
  logic cfg_index = 1'b0;
  logic [8:0] cfg_data = '0;
  logic busy, done, cfg_ready;
  logic signed [31:0] value;
  logic [7:0] segment;
  logic [2:0] status;

  cursor_table_interpolator_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .row(row), .column(column), .x_value(x_value), .y_value(y_value),
    .query(query), .done(done), .value(value), .segment(segment),
    .status(status), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cmd_t    cmd_q[$];
  lookup_t lookup_q[$];
  longint  x_tbl[256];
  longint  y_tbl[1024];
  int      cursor_pos = 0;
  int      rows_reg = 0;
  int      cols_reg = 1;
  int      errors = 0;
  int      burst_left = 0;
  int      gap_left = 0;

  initial forever #2 clk = ~clk;

  function automatic void predict_lookup(input cmd_t t);
    int n, nc, c, i;
    longint q, val, dx, num, dy, sum;
    logic [127:0] prod, quo;
    logic [63:0] un, ud;
    bit neg;
    lookup_t r;
    n = rows_reg > 256 ? 256 : rows_reg;
    nc = cols_reg > 4 ? 4 : cols_reg;
    q = longint'(t.q);
    r = '0;
    if (t.op == OP_NONE) return;
    if (t.op == OP_LOAD) begin
      x_tbl[t.row] = longint'(t.x);
      y_tbl[t.row * 4 + t.col] = longint'(t.y);
      r.status = ST_LOAD;
      lookup_q.insert(lookup_q.size(), r);
      return;
    end
    c = (t.col >= nc) ? 0 : t.col;
    val = 0;
    if (n == 0) begin
      r.status = ST_EMPTY;
    end else if (n == 1) begin
      val = y_tbl[c];
      r.status = ST_SINGLE;
    end else if (t.op == OP_LINEAR ? (q <= x_tbl[0]) : (q < x_tbl[0])) begin
      cursor_pos = 0;
      r.status = ST_BELOW;
      val = (t.op == OP_LINEAR) ? y_tbl[c] : 0;
    end else if (q >= x_tbl[n-1]) begin
      cursor_pos = n - 1;
      r.status = ST_ABOVE;
      val = y_tbl[(n-1) * 4 + c];
    end else begin
      r.status = ST_INSIDE;
      i = cursor_pos < n - 2 ? cursor_pos : n - 2;
      if (t.op == OP_LINEAR) begin
        while (i < n - 1 && x_tbl[i+1] < q) i++;
      end else begin
        while (i < n - 1 && x_tbl[i+1] <= q) i++;
      end
      while (i > 0 && x_tbl[i] > q) i--;
      cursor_pos = i;
      val = y_tbl[i * 4 + c];
      if (t.op == OP_LINEAR && i + 1 < n) begin
        dx = x_tbl[i+1] - x_tbl[i];
        if (dx > 0) begin
          num = q - x_tbl[i];
          dy = y_tbl[(i+1) * 4 + c] - val;
          neg = (num < 0) != (dy < 0);
          un = num < 0 ? -num : num;
          ud = dy < 0 ? -dy : dy;
          prod = {64'd0, un} * {64'd0, ud};
          quo = prod / {64'd0, dx};
          if (quo > (128'd1 << 40)) quo = 128'd1 << 40;
          sum = neg ? val - longint'(quo[63:0]) : val + longint'(quo[63:0]);
          if (sum > 64'sd2147483647) sum = 64'sd2147483647;
          if (sum < -64'sd2147483648) sum = -64'sd2147483648;
          val = sum;
        end
      end
    end
    r.value = val[31:0];
    r.segment = cursor_pos[7:0];
    lookup_q.insert(lookup_q.size(), r);
  endfunction

  always @(posedge clk) begin
    cmd_t nxt;
    bit go;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_lookup(cmd_q.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end
      end
      go = 1'b0;
      nxt = '0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (cmd_q.size() > 0) begin
        go = 1'b1;
        nxt = cmd_q[0];
      end
      start <= go;
      if (go) begin
        operation <= nxt.op;
        row <= nxt.row;
        column <= nxt.col;
        x_value <= nxt.x;
        y_value <= nxt.y;
        query <= nxt.q;
      end
    end
  end

  always @(posedge clk) begin
    lookup_t e;
    if (!rst && done) begin
      if (lookup_q.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        e = lookup_q.pop_front();
        if (value !== e.value) begin
          $error("value expected %0d actual %0d", e.value, value);
          errors++;
        end
        if (segment !== e.segment) begin
          $error("segment expected %0d actual %0d", e.segment, segment);
          errors++;
        end
        if (status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status);
          errors++;
        end
      end
    end
  end

  task automatic push_load(input int r, input int c, input longint x, input longint y);
    cmd_t t;
    @(negedge clk);
    t = '0;
    t.op = OP_LOAD; t.row = 8'(r); t.col = 2'(c); t.x = x[47:0]; t.y = y[31:0];
    t.q = 48'({$urandom, $urandom});
    cmd_q.insert(cmd_q.size(), t);
  endtask

  task automatic push_lookup(input logic [1:0] op, input int c, input longint q);
    cmd_t t;
    @(negedge clk);
    t.op = op; t.row = 8'($urandom); t.col = 2'(c); t.q = q[47:0];
    t.x = 48'({$urandom, $urandom}); t.y = $urandom;
    cmd_q.insert(cmd_q.size(), t);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (cmd_q.size() != 0 || lookup_q.size() != 0 || start || busy);
    repeat (10) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input int data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[8:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_ROWS) rows_reg = data;
    else cols_reg = data;
  endtask

  function automatic longint rand_y(input int kind);
    if (kind == 0) return longint'($signed($urandom));
    return longint'($signed($urandom_range(0, 2000))) - 1000;
  endfunction

  initial begin
    int n, kind, items, k, pick, c;
    longint xv, q;
    int n_choices[12];
    n_choices = '{2, 3, 4, 5, 8, 16, 0, 1, 256, 300, 511, 6};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < 256; r++)
      for (int cc = 0; cc < 4; cc++)
        push_load(r, cc, longint'(r) * 1000 - 5000, rand_y(cc & 1));
    wait_idle();

    push_lookup(OP_LINEAR, 0, 0);
    push_lookup(OP_STEP, 3, 0);
    wait_idle();
    cfg_write(REG_ROWS, 1);
    push_lookup(OP_LINEAR, 2, 12345);
    wait_idle();
    cfg_write(REG_ROWS, 4);
    cfg_write(REG_COLS, 7);
    push_load(255, 3, -64'sd140737488355328, -64'sd2147483648);
    push_load(254, 1, 64'sd140737488355327, 64'sd2147483647);
    push_lookup(OP_LINEAR, 1, -64'sd140737488355328);
    push_lookup(OP_LINEAR, 2, -5000);
    push_lookup(OP_LINEAR, 3, 64'sd140737488355327);
    push_lookup(OP_LINEAR, 0, -3500);
    push_lookup(OP_STEP, 1, -5001);
    push_lookup(OP_STEP, 1, -5000);
    push_lookup(OP_STEP, 2, -2500);
    push_lookup(OP_NONE, 3, 0);
    push_lookup(OP_LINEAR, 1, -4999);
    wait_idle();
    cfg_write(REG_COLS, 2);
    push_lookup(OP_LINEAR, 3, -3200);
    push_lookup(OP_STEP, 2, -1000);
    wait_idle();
    cfg_write(REG_COLS, 0);
    push_lookup(OP_LINEAR, 1, -4100);
    wait_idle();

    items = 0;
    while (items < 750) begin
      n = ($urandom_range(0, 9) == 0) ? n_choices[$urandom_range(6, 11)]
                                       : n_choices[$urandom_range(0, 5)];
      if (n == 256 && $urandom_range(0, 2) != 0) n = 16;
      kind = $urandom_range(0, 3);
      cfg_write(REG_ROWS, n);
      cfg_write(REG_COLS, $urandom_range(0, 7));
      xv = longint'($signed($urandom)) * ($urandom_range(0, 1) ? 65536 : 1);
      for (int r = 0; r < (n > 256 ? 256 : n); r++) begin
        case (kind)
          0: xv = xv + $urandom_range(1, 1 << 20) * ($urandom_range(0, 3) == 0 ? 4096 : 1);
          1: xv = xv + $urandom_range(0, 2);
          2: xv = $urandom_range(0, 7);
          default: xv = longint'($signed({$urandom, $urandom} >> 16));
        endcase
        if (xv > 64'sd140737488355327) xv = 64'sd140737488355327;
        push_load(r, $urandom_range(0, 3), xv, rand_y($urandom_range(0, 1)));
        items++;
      end
      wait_idle();
      for (int j = 0; j < 40; j++) begin
        pick = $urandom_range(0, 19);
        c = $urandom_range(0, 3);
        k = $urandom_range(0, 255);
        if (n > 0 && n <= 256) k = $urandom_range(0, n - 1);
        if (pick == 0) begin
          push_load($urandom_range(0, 255), c, longint'($signed({$urandom, $urandom} >> 16)),
                    rand_y(0));
        end else if (pick == 1) begin
          push_lookup(OP_NONE, c, 0);
        end else begin
          case ($urandom_range(0, 3))
            0: q = x_tbl[k];
            1: q = x_tbl[k] + longint'($signed($urandom_range(0, 6))) - 3;
            2: q = x_tbl[k] + longint'($signed($urandom_range(0, 1 << 22))) - (1 << 21);
            default: q = longint'($signed({$urandom, $urandom} >> 16));
          endcase
          push_lookup(pick[0] ? OP_LINEAR : OP_STEP, c, q);
        end
        items++;
      end
      wait_idle();
    end

    repeat (200) @(posedge clk);
    if (errors == 0 && lookup_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
